// File: design/hbpx_pkg.sv
// Shared types and constants for the variable-length code bit packer.
`timescale 1ns / 1ps
package hbpx_pkg;

   localparam int MAX_CODE_BITS = 32;
   localparam int CODE_WIDTH    = 32;
   localparam int LEN_WIDTH     = 6;
   localparam int BYTE_WIDTH    = 8;
   localparam int VBITS_WIDTH   = 4;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_WIDTH-1:0] LEN_LIMIT =
      LEN_WIDTH'((MAX_CODE_BITS < CODE_WIDTH) ? MAX_CODE_BITS : CODE_WIDTH);

   localparam logic [VBITS_WIDTH-1:0] FULL_BYTE = VBITS_WIDTH'(BYTE_WIDTH);

   typedef struct packed {
      logic [CODE_WIDTH-1:0] code_value;
      logic [LEN_WIDTH-1:0]  code_length;
      logic                  last_item;
   } code_entry_type;

   typedef struct packed {
      logic           valid;
      code_entry_type entry;
   } queue_head_type;

endpackage

// File: design/hbpx_front.sv
// Request intake: clamps the code length and queues requests for the packer.
`timescale 1ns / 1ps
module hbpx_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [hbpx_pkg::CODE_WIDTH-1:0]        req_code_value,
   input  logic [hbpx_pkg::LEN_WIDTH-1:0]         req_code_length,
   input  logic                                   req_last_item,
   output hbpx_pkg::queue_head_type               q_head,
   input  logic                                   q_pop
);

   localparam int PW = hbpx_pkg::QPTR_WIDTH;
   localparam int NW = hbpx_pkg::QCNT_WIDTH;

   hbpx_pkg::code_entry_type              queue_ff [hbpx_pkg::QUEUE_DEPTH];
   logic [PW-1:0]                         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]                         rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]                         count_ff, count_in;
   hbpx_pkg::code_entry_type              entry;
   logic                                  push;
   logic                                  pop;

   assign req_stall = (count_ff == NW'(hbpx_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (count_ff != '0);

   always_comb begin
      entry.code_value  = req_code_value;
      entry.code_length = (req_code_length > hbpx_pkg::LEN_LIMIT) ?
                          hbpx_pkg::LEN_LIMIT : req_code_length;
      entry.last_item   = req_last_item;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.entry = queue_ff[rd_ptr_ff];

endmodule

// File: design/hbpx_back.sv
// Packing engine: shifts code bits into bytes, keeps the checksum, drives responses.
`timescale 1ns / 1ps
module hbpx_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  hbpx_pkg::queue_head_type               q_head,
   output logic                                   q_pop,
   input  logic                                   csr_wr_en,
   input  logic [hbpx_pkg::BYTE_WIDTH-1:0]        csr_checksum_seed,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [hbpx_pkg::BYTE_WIDTH-1:0]        rsp_out_byte,
   output logic                                   rsp_has_byte,
   output logic [hbpx_pkg::VBITS_WIDTH-1:0]       rsp_valid_bits,
   output logic [hbpx_pkg::BYTE_WIDTH-1:0]        rsp_running_checksum,
   output logic                                   rsp_end_of_run
);

   localparam int BW  = hbpx_pkg::BYTE_WIDTH;
   localparam int VW  = hbpx_pkg::VBITS_WIDTH;
   localparam int LW  = hbpx_pkg::LEN_WIDTH;
   localparam int CW  = hbpx_pkg::CODE_WIDTH;

   logic                busy_ff, busy_in;
   logic [CW-1:0]       value_ff, value_in;
   logic [LW-1:0]       rem_ff, rem_in;
   logic                last_ff, last_in;
   logic [BW-1:0]       bits_ff, bits_in;
   logic [VW-1:0]       cnt_ff, cnt_in;
   logic [BW-1:0]       xor_ff, xor_in;
   logic [BW-1:0]       seed_ff, seed_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]       rsp_byte_ff, rsp_byte_in;
   logic                rsp_has_ff, rsp_has_in;
   logic [VW-1:0]       rsp_vbits_ff, rsp_vbits_in;
   logic [BW-1:0]       rsp_sum_ff, rsp_sum_in;
   logic                rsp_end_ff, rsp_end_in;

   logic                out_free;
   logic                emit_byte;
   logic                emit_flush;
   logic                emit;
   logic                step;
   logic                done;
   logic [BW-1:0]       base_bits;
   logic [VW-1:0]       base_cnt;
   logic [VW-1:0]       room;
   logic [VW-1:0]       take;
   logic [LW-1:0]       rem_next;
   logic [CW-1:0]       shifted;
   logic [BW-1:0]       take_mask;
   logic [BW-1:0]       new_bits;
   logic [BW-1:0]       flush_byte;
   logic [BW-1:0]       res_byte;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_byte  = busy_ff && (cnt_ff == hbpx_pkg::FULL_BYTE) && (rem_ff != '0);
   assign emit_flush = busy_ff && (rem_ff == '0) && last_ff;
   assign emit       = emit_byte || emit_flush;
   assign step       = busy_ff && (!emit || out_free);

   always_comb begin
      base_bits  = emit_byte ? '0 : bits_ff;
      base_cnt   = emit_byte ? '0 : cnt_ff;
      room       = hbpx_pkg::FULL_BYTE - base_cnt;
      take       = (rem_ff < LW'(room)) ? VW'(rem_ff) : room;
      rem_next   = rem_ff - LW'(take);
      shifted    = value_ff >> rem_next;
      take_mask  = BW'((16'd1 << take) - 16'd1);
      new_bits   = BW'((16'(base_bits) << take) | 16'(shifted[BW-1:0] & take_mask));
      flush_byte = BW'(16'(bits_ff) << (hbpx_pkg::FULL_BYTE - cnt_ff));
      done       = emit_flush || ((rem_next == '0) && !last_ff);
      res_byte   = emit_byte ? bits_ff : ((cnt_ff == '0) ? '0 : flush_byte);
   end

   assign q_pop = q_head.valid && (!busy_ff || (step && done));

   always_comb begin
      busy_in  = busy_ff;
      value_in = value_ff;
      rem_in   = rem_ff;
      last_in  = last_ff;
      bits_in  = bits_ff;
      cnt_in   = cnt_ff;
      xor_in   = xor_ff;
      seed_in  = seed_ff;
      if (step) begin
         rem_in  = rem_next;
         bits_in = new_bits;
         cnt_in  = base_cnt + take;
         if (emit_byte) begin
            xor_in = xor_ff ^ bits_ff;
         end
         if (emit_flush) begin
            bits_in = '0;
            cnt_in  = '0;
            xor_in  = seed_ff;
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in  = 1'b1;
         value_in = q_head.entry.code_value;
         rem_in   = q_head.entry.code_length;
         last_in  = q_head.entry.last_item;
      end
      if (csr_wr_en) begin
         seed_in = csr_checksum_seed;
         xor_in  = csr_checksum_seed;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_vbits_in = rsp_vbits_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_end_in   = rsp_end_ff;
      if (step && emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = res_byte;
         rsp_has_in   = emit_byte || (cnt_ff != '0);
         rsp_vbits_in = (emit_byte || (cnt_ff == '0)) ? hbpx_pkg::FULL_BYTE : cnt_ff;
         rsp_sum_in   = xor_ff ^ res_byte;
         rsp_end_in   = done;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rem_ff       <= '0;
         last_ff      <= 1'b0;
         bits_ff      <= '0;
         cnt_ff       <= '0;
         xor_ff       <= '0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rem_ff       <= rem_in;
         last_ff      <= last_in;
         bits_ff      <= bits_in;
         cnt_ff       <= cnt_in;
         xor_ff       <= xor_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_vbits_ff <= rsp_vbits_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_byte         = rsp_byte_ff;
   assign rsp_has_byte         = rsp_has_ff;
   assign rsp_valid_bits       = rsp_vbits_ff;
   assign rsp_running_checksum = rsp_sum_ff;
   assign rsp_end_of_run       = rsp_end_ff;

endmodule

// File: design/huffman_bit_packer_xor_core.sv
// Top level of the variable-length code bit packer with XOR checksum.
// Usage:
//   Each request carries one code word (code_value, code_length, last_item).
//   Bits are packed MSB first; a full byte is sent once a further bit
//   arrives, and a request with last_item set flushes the held bits,
//   zero padded, with the bit count and final checksum, then restarts the
//   checksum from the seed. An empty flush returns has_byte 0, valid_bits 8.
//   csr_wr_en loads the seed and the running checksum; write only when idle.
// Queue and throughput:
//   A request enters a four-entry queue; the packer takes up to eight bits
//   and sends at most one byte per cycle, so a request stays in the packer
//   until all its bits are taken, and longer while rsp_stall holds a byte.
//   A request passes the queue and the packer state before its response is registered.
// Reset and stall:
//   Reset empties the queue, clears held bits and zeroes seed and checksum.
//   While rsp_stall is high the response holds; the packer waits on the
//   next byte and req_stall rises once the queue is full.
`timescale 1ns / 1ps
module huffman_bit_packer_xor_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [hbpx_pkg::CODE_WIDTH-1:0]        req_code_value,
   input  logic [hbpx_pkg::LEN_WIDTH-1:0]         req_code_length,
   input  logic                                   req_last_item,
   input  logic                                   csr_wr_en,
   input  logic [hbpx_pkg::BYTE_WIDTH-1:0]        csr_checksum_seed,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [hbpx_pkg::BYTE_WIDTH-1:0]        rsp_out_byte,
   output logic                                   rsp_has_byte,
   output logic [hbpx_pkg::VBITS_WIDTH-1:0]       rsp_valid_bits,
   output logic [hbpx_pkg::BYTE_WIDTH-1:0]        rsp_running_checksum,
   output logic                                   rsp_end_of_run
);

   hbpx_pkg::queue_head_type q_head;
   logic                     q_pop;

   hbpx_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_value  (req_code_value),
      .req_code_length (req_code_length),
      .req_last_item   (req_last_item),
      .q_head          (q_head),
      .q_pop           (q_pop)
   );

   hbpx_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_head               (q_head),
      .q_pop                (q_pop),
      .csr_wr_en            (csr_wr_en),
      .csr_checksum_seed    (csr_checksum_seed),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_has_byte         (rsp_has_byte),
      .rsp_valid_bits       (rsp_valid_bits),
      .rsp_running_checksum (rsp_running_checksum),
      .rsp_end_of_run       (rsp_end_of_run)
   );

endmodule
